// File: rtl/w3s_pkg.sv
// w3s_pkg: shared constants, types and helpers of the 3x3 smoothing filter
// no dependencies; imported by every module of the block
`default_nettype none

package w3s_pkg;

  // image geometry and pixel format
  localparam int unsigned MAX_SIZE   = 1024;
  localparam int unsigned PIXEL_BITS = 16;
  localparam int unsigned ADDR_BITS  = $clog2(MAX_SIZE);
  localparam int unsigned CNT_BITS   = ADDR_BITS;
  localparam int unsigned SIZE_BITS  = 11;

  // coefficient format, unsigned Q1.15
  localparam int unsigned COEF_BITS = 16;
  localparam int unsigned COEF_FRAC = 15;

  // datapath widths: four-pixel sums, products and the final accumulator
  localparam int unsigned SUM_BITS   = PIXEL_BITS + 2;
  localparam int unsigned PROD_BITS  = COEF_BITS + SUM_BITS;
  localparam int unsigned CPROD_BITS = COEF_BITS + PIXEL_BITS;
  localparam int unsigned ACC_BITS   = PROD_BITS + 2;

  // queue between front and back end
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = FIFO_PTR_BITS + 1;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_SIZE  = 2'd0,
    REG_CORNER_COEF = 2'd1,
    REG_EDGE_COEF   = 2'd2,
    REG_CENTER_COEF = 2'd3
  } w3s_reg_e;

  localparam logic [SIZE_BITS-1:0] SIZE_RST   = SIZE_BITS'(1024);
  localparam logic [COEF_BITS-1:0] CORNER_RST = COEF_BITS'(1638);
  localparam logic [COEF_BITS-1:0] EDGE_RST   = COEF_BITS'(3277);
  localparam logic [COEF_BITS-1:0] CENTER_RST = COEF_BITS'(13107);

  localparam logic [SIZE_BITS-1:0] SIZE_MIN = SIZE_BITS'(3);
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = SIZE_BITS'(MAX_SIZE);

  // one window ready for weighting
  typedef struct packed {
    logic [SUM_BITS-1:0]   diag_sum;
    logic [SUM_BITS-1:0]   side_sum;
    logic [PIXEL_BITS-1:0] center;
    logic [CNT_BITS-1:0]   row;
    logic [CNT_BITS-1:0]   col;
    logic                  last;
  } w3s_item_t;

  // filter weights
  typedef struct packed {
    logic [COEF_BITS-1:0] corner_w;
    logic [COEF_BITS-1:0] edge_w;
    logic [COEF_BITS-1:0] center_w;
  } w3s_coef_t;

  // effective image size, clamped to the legal range
  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] sz);
    logic [SIZE_BITS-1:0] res;
    res = sz;
    if (sz < SIZE_MIN) begin
      res = SIZE_MIN;
    end else if (sz > SIZE_MAX) begin
      res = SIZE_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/w3s_front.sv
// w3s_front: pixel intake, raster counters, two line stores and the 3x3 window
// depends on w3s_pkg; emits one w3s_item_t per interior centre pixel
`default_nettype none

module w3s_front import w3s_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SIZE_BITS-1:0]  size_i,
  input  wire logic                  restart_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                       push_o,
  output w3s_item_t                  item_o,
  input  wire logic                  q_ready_i
);

  logic [SIZE_BITS-1:0] size_eff;
  logic                 accept;

  // raster position of the next pixel
  logic [CNT_BITS-1:0] row_q, row_d;
  logic [CNT_BITS-1:0] col_q, col_d;

  // stage 1: accepted pixel plus registered line store reads
  logic                  s1_valid_q, s1_valid_d;
  logic [PIXEL_BITS-1:0] s1_pix_q;
  logic [CNT_BITS-1:0]   s1_row_q;
  logic [CNT_BITS-1:0]   s1_col_q;
  logic [PIXEL_BITS-1:0] top_q;
  logic [PIXEL_BITS-1:0] mid_q;
  logic                  s1_has_res;
  logic                  s1_adv;

  // line stores and window: [0..2] column c-1, [3..5] column c-2
  logic [PIXEL_BITS-1:0] upper_mem [MAX_SIZE];
  logic [PIXEL_BITS-1:0] middle_mem [MAX_SIZE];
  logic [PIXEL_BITS-1:0] win_q [6];

  assign size_eff   = clamp_size(size_i);
  assign s1_has_res = (s1_row_q >= CNT_BITS'(2)) && (s1_col_q >= CNT_BITS'(2));
  assign s1_adv     = s1_valid_q && (!s1_has_res || q_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // counter advance with row and frame wrap
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if ((SIZE_BITS'(col_q) + SIZE_BITS'(1)) >= size_eff) begin
        col_d = '0;
        if ((SIZE_BITS'(row_q) + SIZE_BITS'(1)) >= size_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + CNT_BITS'(1);
        end
      end else begin
        col_d = col_q + CNT_BITS'(1);
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pixel_in_i;
      s1_row_q <= row_q;
      s1_col_q <= col_q;
    end
  end

  // line stores: read on accept, write back when stage 1 retires
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= upper_mem[col_q];
      mid_q <= middle_mem[col_q];
    end
    if (s1_adv) begin
      upper_mem[s1_col_q]  <= mid_q;
      middle_mem[s1_col_q] <= s1_pix_q;
    end
  end

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_adv) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= top_q;
      win_q[1] <= mid_q;
      win_q[2] <= s1_pix_q;
    end
  end

  // neighbour sums and centre position
  always_comb begin
    item_o.diag_sum = SUM_BITS'(win_q[3]) + SUM_BITS'(win_q[5])
                    + SUM_BITS'(top_q) + SUM_BITS'(s1_pix_q);
    item_o.side_sum = SUM_BITS'(win_q[0]) + SUM_BITS'(win_q[2])
                    + SUM_BITS'(win_q[4]) + SUM_BITS'(mid_q);
    item_o.center   = win_q[1];
    item_o.row      = s1_row_q - CNT_BITS'(1);
    item_o.col      = s1_col_q - CNT_BITS'(1);
    item_o.last     = (SIZE_BITS'(s1_row_q) == (size_eff - SIZE_BITS'(1)))
                   && (SIZE_BITS'(s1_col_q) == (size_eff - SIZE_BITS'(1)));
  end

  assign push_o = s1_adv && s1_has_res;

endmodule

`default_nettype wire

// File: rtl/w3s_fifo.sv
// w3s_fifo: short queue of windows between front end and weighting back end
// depends on w3s_pkg for the entry type and depth
`default_nettype none

module w3s_fifo import w3s_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire w3s_item_t push_item_i,
  output logic           not_full_o,
  input  wire logic      pop_i,
  output logic           not_empty_o,
  output w3s_item_t      pop_item_o
);

  w3s_item_t                entries_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                     do_push, do_pop;

  assign not_full_o  = (cnt_q != FIFO_CNT_BITS'(FIFO_DEPTH));
  assign not_empty_o = (cnt_q != '0);
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_item_o  = entries_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_BITS'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - FIFO_CNT_BITS'(1);
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  // fill level stays within the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("w3s_fifo: fill level above depth");

  // a lone push grows the level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + FIFO_CNT_BITS'(1)))
    else $error("w3s_fifo: push not counted");

  // a lone pop shrinks the level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - FIFO_CNT_BITS'(1)))
    else $error("w3s_fifo: pop not counted");

  // pointers are apart by the fill level, modulo the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    FIFO_PTR_BITS'(wr_ptr_q - rd_ptr_q) == FIFO_PTR_BITS'(cnt_q))
    else $error("w3s_fifo: pointers out of step with level");
`endif

endmodule

`default_nettype wire

// File: rtl/w3s_back.sv
// w3s_back: weighting back end, three products then sum, truncate, saturate
// depends on w3s_pkg; drains the window queue into the output register
`default_nettype none

module w3s_back import w3s_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire w3s_coef_t              coef_i,
  input  wire logic                   q_not_empty_i,
  input  wire w3s_item_t              q_item_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [PIXEL_BITS-1:0]       smoothed_o,
  output logic [CNT_BITS-1:0]         out_row_o,
  output logic [CNT_BITS-1:0]         out_col_o,
  output logic                        frame_last_o
);

  // multiply stage
  logic                  m_valid_q;
  logic [PROD_BITS-1:0]  prod_c_q, prod_c_d;
  logic [PROD_BITS-1:0]  prod_e_q, prod_e_d;
  logic [CPROD_BITS-1:0] prod_m_q, prod_m_d;
  logic [CNT_BITS-1:0]   m_row_q, m_col_q;
  logic                  m_last_q;
  logic                  m_ready;

  // output stage
  logic                  o_valid_q;
  logic [PIXEL_BITS-1:0] res_q, res_d;
  logic [CNT_BITS-1:0]   o_row_q, o_col_q;
  logic                  o_last_q;
  logic                  o_ready;
  logic [ACC_BITS-1:0]   acc;

  assign o_ready = !o_valid_q || out_ready_i;
  assign m_ready = !m_valid_q || o_ready;
  assign q_pop_o = q_not_empty_i && m_ready;

  // weighted products
  assign prod_c_d = PROD_BITS'(coef_i.corner_w) * PROD_BITS'(q_item_i.diag_sum);
  assign prod_e_d = PROD_BITS'(coef_i.edge_w) * PROD_BITS'(q_item_i.side_sum);
  assign prod_m_d = CPROD_BITS'(coef_i.center_w) * CPROD_BITS'(q_item_i.center);

  // sum, drop fraction bits, clip at full scale
  always_comb begin
    acc = ACC_BITS'(prod_c_q) + ACC_BITS'(prod_e_q) + ACC_BITS'(prod_m_q);
    if (acc[ACC_BITS-1:COEF_FRAC+PIXEL_BITS] != '0) begin
      res_d = '1;
    end else begin
      res_d = acc[COEF_FRAC+PIXEL_BITS-1:COEF_FRAC];
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_q <= q_pop_o;
      end
      if (o_ready) begin
        o_valid_q <= m_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prod_c_q <= prod_c_d;
      prod_e_q <= prod_e_d;
      prod_m_q <= prod_m_d;
      m_row_q  <= q_item_i.row;
      m_col_q  <= q_item_i.col;
      m_last_q <= q_item_i.last;
    end
    if (o_ready && m_valid_q) begin
      res_q    <= res_d;
      o_row_q  <= m_row_q;
      o_col_q  <= m_col_q;
      o_last_q <= m_last_q;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign smoothed_o   = res_q;
  assign out_row_o    = o_row_q;
  assign out_col_o    = o_col_q;
  assign frame_last_o = o_last_q;

endmodule

`default_nettype wire

// File: rtl/weighted_3x3_smoothing.sv
// weighted_3x3_smoothing: 3x3 symmetric smoothing of a raster image stream.
// Throughput: one pixel per cycle unless the queue or the output stalls; each line
// store takes one read and one write per cycle.
// Path: a result passes the stage 1 register (line store read and window sums),
// the queue (write), the product register and the output register (sum and saturate).
// Reset: counters, window, queue and stage valids clear; registers take defaults.
`default_nettype none

module weighted_3x3_smoothing import w3s_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [PIXEL_BITS-1:0]    pixel_in_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [PIXEL_BITS-1:0]         smoothed_o,
  output logic [CNT_BITS-1:0]           out_row_o,
  output logic [CNT_BITS-1:0]           out_col_o,
  output logic                          frame_last_o
);

  logic [SIZE_BITS-1:0] size_q;
  w3s_coef_t            coef_q;
  logic                 restart;
  logic                 push, q_not_full, q_not_empty, q_pop;
  w3s_item_t            push_item, pop_item;

  assign restart = cfg_we_i && (w3s_reg_e'(cfg_idx_i) == REG_IMAGE_SIZE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q          <= SIZE_RST;
      coef_q.corner_w <= CORNER_RST;
      coef_q.edge_w   <= EDGE_RST;
      coef_q.center_w <= CENTER_RST;
    end else if (cfg_we_i) begin
      unique case (w3s_reg_e'(cfg_idx_i))
        REG_IMAGE_SIZE:  size_q          <= cfg_data_i[SIZE_BITS-1:0];
        REG_CORNER_COEF: coef_q.corner_w <= cfg_data_i[COEF_BITS-1:0];
        REG_EDGE_COEF:   coef_q.edge_w   <= cfg_data_i[COEF_BITS-1:0];
        REG_CENTER_COEF: coef_q.center_w <= cfg_data_i[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // intake and window forming
  w3s_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_q),
    .restart_i  (restart),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_in_i (pixel_in_i),
    .push_o     (push),
    .item_o     (push_item),
    .q_ready_i  (q_not_full)
  );

  // decoupling queue
  w3s_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .not_full_o  (q_not_full),
    .pop_i       (q_pop),
    .not_empty_o (q_not_empty),
    .pop_item_o  (pop_item)
  );

  // weighting and output register
  w3s_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef_q),
    .q_not_empty_i (q_not_empty),
    .q_item_i      (pop_item),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .smoothed_o    (smoothed_o),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

`default_nettype wire

// File: tb/sv/w3s_checker.sv
// w3s_checker: watches the pixel and result channels of the smoothing filter,
// predicts every result from the accepted pixels and compares field by field
// depends on w3s_pkg for widths, register codes and reset values
`timescale 1ns / 1ps

module w3s_checker import w3s_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic [PIXEL_BITS-1:0]    pixel_in_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic [PIXEL_BITS-1:0]    smoothed_i,
  input  wire logic [CNT_BITS-1:0]      out_row_i,
  input  wire logic [CNT_BITS-1:0]      out_col_i,
  input  wire logic                     frame_last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] value;
    logic [CNT_BITS-1:0]   row;
    logic [CNT_BITS-1:0]   col;
    logic                  last;
  } smoothed_t;

  smoothed_t smoothed_q[$];

  // predictor state: rows two and one above the incoming pixel, 3x2 window
  logic [PIXEL_BITS-1:0] row_above [MAX_SIZE];
  logic [PIXEL_BITS-1:0] row_prev  [MAX_SIZE];
  logic [PIXEL_BITS-1:0] win [6];
  int unsigned           row_pos;
  int unsigned           col_pos;
  logic [SIZE_BITS-1:0]  size_reg;
  logic [COEF_BITS-1:0]  corner_w;
  logic [COEF_BITS-1:0]  edge_w;
  logic [COEF_BITS-1:0]  center_w;
  int                    fails;
  int                    checked;

  // frame side length actually used for a programmed size
  function automatic int unsigned frame_dim(input logic [SIZE_BITS-1:0] raw);
    if (raw < 3) begin
      return 3;
    end
    if (raw > MAX_SIZE) begin
      return MAX_SIZE;
    end
    return raw;
  endfunction

  // one accepted pixel: emit the interior result it completes, then shift
  task automatic take_pixel(input logic [PIXEL_BITS-1:0] pix);
    int unsigned           dim;
    logic [PIXEL_BITS-1:0] top;
    logic [PIXEL_BITS-1:0] mid;
    logic [SUM_BITS-1:0]   diag;
    logic [SUM_BITS-1:0]   side;
    logic [63:0]           acc;
    smoothed_t             res;
    dim = frame_dim(size_reg);
    if (row_pos >= dim || col_pos >= dim) begin
      row_pos = 0;
      col_pos = 0;
    end
    top = row_above[col_pos];
    mid = row_prev[col_pos];
    if (row_pos >= 2 && col_pos >= 2) begin
      // win[3..5] is the left column, win[0..2] the centre column
      diag = SUM_BITS'(win[3]) + SUM_BITS'(win[5]) + SUM_BITS'(top) + SUM_BITS'(pix);
      side = SUM_BITS'(win[0]) + SUM_BITS'(win[2]) + SUM_BITS'(win[4]) + SUM_BITS'(mid);
      acc = 64'(corner_w) * 64'(diag) + 64'(edge_w) * 64'(side)
          + 64'(center_w) * 64'(win[1]);
      acc = acc >> COEF_FRAC;
      res.value = ((acc >> PIXEL_BITS) != 0) ? '1 : acc[PIXEL_BITS-1:0];
      res.row   = CNT_BITS'(row_pos - 1);
      res.col   = CNT_BITS'(col_pos - 1);
      res.last  = (row_pos == dim - 1) && (col_pos == dim - 1);
      smoothed_q.push_back(res);
    end
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = pix;
    row_above[col_pos] = mid;
    row_prev[col_pos]  = pix;
    col_pos++;
    if (col_pos >= dim) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= dim) begin
        row_pos = 0;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [PIXEL_BITS-1:0] want,
                               input logic [PIXEL_BITS-1:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // sample configuration, pixel and result transactions at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    smoothed_t exp_r;
    if (!rst_ni) begin
      size_reg = SIZE_RST;
      corner_w = CORNER_RST;
      edge_w   = EDGE_RST;
      center_w = CENTER_RST;
      row_pos  = 0;
      col_pos  = 0;
      for (int k = 0; k < 6; k++) begin
        win[k] = '0;
      end
      for (int k = 0; k < MAX_SIZE; k++) begin
        row_above[k] = '0;
        row_prev[k]  = '0;
      end
      smoothed_q.delete();
      fails   = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (w3s_reg_e'(cfg_idx_i))
          REG_IMAGE_SIZE: begin
            size_reg = cfg_data_i[SIZE_BITS-1:0];
            row_pos  = 0;
            col_pos  = 0;
          end
          REG_CORNER_COEF: corner_w = cfg_data_i[COEF_BITS-1:0];
          REG_EDGE_COEF:   edge_w   = cfg_data_i[COEF_BITS-1:0];
          REG_CENTER_COEF: center_w = cfg_data_i[COEF_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        take_pixel(pixel_in_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (smoothed_q.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected, actual value %h row %0d col %0d last %b",
                   $time, smoothed_i, out_row_i, out_col_i, frame_last_i);
        end else begin
          exp_r = smoothed_q.pop_front();
          compare_field("smoothed", exp_r.value, smoothed_i);
          compare_field("out_row", PIXEL_BITS'(exp_r.row), PIXEL_BITS'(out_row_i));
          compare_field("out_col", PIXEL_BITS'(exp_r.col), PIXEL_BITS'(out_col_i));
          compare_field("frame_last", PIXEL_BITS'(exp_r.last), PIXEL_BITS'(frame_last_i));
          checked++;
        end
      end
      fail_count_o <= fails;
      pending_o    <= smoothed_q.size();
      checked_o    <= checked;
    end
  end

endmodule

// File: tb/sv/weighted_3x3_smoothing_tb.sv
// weighted_3x3_smoothing_tb: drives pixel frames, register settings and output
// back-pressure into the smoothing filter; checking sits in w3s_checker
// depends on w3s_pkg, w3s_checker and the weighted_3x3_smoothing RTL
`timescale 1ns / 1ps

module weighted_3x3_smoothing_tb;
  import w3s_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_PAD   = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 29;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [PIXEL_BITS-1:0]    pixel_in_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [PIXEL_BITS-1:0]    smoothed_o;
  logic [CNT_BITS-1:0]      out_row_o;
  logic [CNT_BITS-1:0]      out_col_o;
  logic                     frame_last_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int pixels_sent = 0;
  int hold_seq = 0;
  int max_dim = 0;
  bit steady = 1'b0;

  weighted_3x3_smoothing dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .smoothed_o   (smoothed_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

  w3s_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .pixel_in_i   (pixel_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .smoothed_i   (smoothed_o),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .frame_last_i (frame_last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    int          seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // one pixel transaction, with random idle cycles in front of it
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    pixels_sent++;
  endtask

  task automatic run_pixels(input int count);
    logic [PIXEL_BITS-1:0] pix;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 7))
        0:       pix = '0;
        1:       pix = '1;
        default: pix = PIXEL_BITS'($urandom);
      endcase
      send_pixel(pix);
    end
  endtask

  // stop offering, wait for every expected result, then let the pipe empty
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_PAD) @(posedge clk_i);
  endtask

  task automatic configure(input bit wr_size, input logic [CFG_DATA_BITS-1:0] size_val,
                           input bit wr_corner, input logic [CFG_DATA_BITS-1:0] corner_val,
                           input bit wr_edge, input logic [CFG_DATA_BITS-1:0] edge_val,
                           input bit wr_center, input logic [CFG_DATA_BITS-1:0] center_val);
    int dim;
    if (wr_size) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_IMAGE_SIZE;
      cfg_data_i <= size_val;
      @(posedge clk_i);
      dim = size_val[SIZE_BITS-1:0];
      if (dim < 3) dim = 3;
      if (dim > MAX_SIZE) dim = MAX_SIZE;
      if (dim > max_dim) max_dim = dim;
    end
    if (wr_corner) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_CORNER_COEF;
      cfg_data_i <= corner_val;
      @(posedge clk_i);
    end
    if (wr_edge) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_EDGE_COEF;
      cfg_data_i <= edge_val;
      @(posedge clk_i);
    end
    if (wr_center) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_CENTER_COEF;
      cfg_data_i <= center_val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // weight mix: zero, full scale, small values, anything
  function automatic logic [CFG_DATA_BITS-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return CFG_DATA_BITS'($urandom_range(0, 8191));
      default: return CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [PIXEL_BITS-1:0]    ramp [4] = '{16'h1234, 16'hFFFF, 16'h0000, 16'h8000};
    logic [PIXEL_BITS-1:0]    mixed [9] = '{16'h0000, 16'hFFFF, 16'h0000,
                                            16'hFFFF, 16'h8000, 16'hFFFF,
                                            16'h0000, 16'hFFFF, 16'h0001};
    logic [SIZE_BITS-1:0]     raw;
    logic [CFG_DATA_BITS-1:0] size_word;
    int                       small_items;
    int                       phase;
    int                       count;
    bit                       wr_size;
    bit                       big_now;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // partial frame, then a size write must restart the frame; the stored
    // size 1 (upper data bits set) behaves as 3
    configure(1'b1, 16'd3, 1'b0, '0, 1'b0, '0, 1'b0, '0);
    foreach (ramp[k]) send_pixel(ramp[k]);
    wait_drained();
    configure(1'b1, 16'hF801, 1'b0, '0, 1'b0, '0, 1'b0, '0);
    foreach (mixed[k]) send_pixel(mixed[k]);
    wait_drained();

    // full-scale weights on a white frame saturate; counters wrap into it
    configure(1'b0, '0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
    repeat (9) send_pixel(16'hFFFF);
    wait_drained();

    // random phases; phase 0 also carries the long receiver hold-off
    small_items = 0;
    phase = 0;
    big_now = 1'b0;
    while (small_items < 1000) begin
      steady = (phase < 2);
      if (phase == 5) begin
        // largest frame through an oversize write; pixels reach the third row, which yields results
        configure(1'b1, 16'hFFFF, $urandom_range(0, 1), rand_coef(),
                  $urandom_range(0, 1), rand_coef(), $urandom_range(0, 1), rand_coef());
        run_pixels(2 * MAX_SIZE + 24);
        big_now = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0:       raw = SIZE_BITS'($urandom_range(0, 2));
          1:       raw = SIZE_BITS'($urandom_range(13, 40));
          default: raw = SIZE_BITS'($urandom_range(3, 12));
        endcase
        if (phase == 0) raw = SIZE_BITS'($urandom_range(3, 4));
        size_word = $urandom_range(0, 1) ? {5'($urandom), raw} : CFG_DATA_BITS'(raw);
        wr_size = big_now || (phase == 0) || ($urandom_range(0, 2) != 0);
        configure(wr_size, size_word, $urandom_range(0, 1), rand_coef(),
                  $urandom_range(0, 1), rand_coef(), $urandom_range(0, 1), rand_coef());
        big_now = 1'b0;
        count = (phase == 0) ? 100 : $urandom_range(10, 100);
        if (phase == 0) hold_seq++;
        run_pixels(count);
        small_items += count;
      end
      wait_drained();
      phase++;
    end
    steady = 1'b0;
    wait_drained();

    $display("summary: %0d pixels over %0d random phases, %0d results compared",
             pixels_sent, phase, checked);
    $display("summary: frame sizes 3 to %0d, weights 0 to full scale, %0d-cycle output hold-off",
             max_dim, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
